### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file kt_chk.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/kt_pkg.sv
// ----------------------------------------------------------------------------
// kt_pkg
// Types and constants for the Kendall tau rank grid unit.
// ----------------------------------------------------------------------------
package kt_pkg;

    localparam int ROWS       = 64;
    localparam int COLS       = 64;
    localparam int COUNT_BITS = 16;

    localparam int RANK_W    = 6;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(COLS);
    localparam int DEPTH     = ROWS * COLS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = COUNT_BITS;
    localparam int PRE_W     = CNT_W + 2;
    localparam int PROD_W    = PRE_W + CNT_W + 1;
    localparam int SUM_W     = 32;
    localparam int P_W       = 2 * CNT_W;
    localparam int DIV_W     = 32;
    localparam int Q_W       = 15;
    localparam int DIV_STEPS = 15;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};
    localparam logic [63:0]      PAIR_LIMIT = 64'h0000_0000_7FFF_FFFF;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_FIN = 1'b1;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_RANK = 2'd1;
    localparam logic [1:0] ERR_FEW  = 2'd2;
    localparam logic [1:0] ERR_OVF  = 2'd3;

    typedef struct packed {
        logic              command;
        logic [RANK_W-1:0] first_rank;
        logic [RANK_W-1:0] second_rank;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] tau_fixed;
        logic signed [31:0] concordance_sum;
        logic [30:0]        pair_total;
        logic [1:0]         error_code;
    } t_out_item;

    typedef struct packed {
        logic clr_wr;
        logic add_acc;
        logic fin_acc;
        logic add_wr;
        logic walk_rd;
        logic walk_mul;
        logic walk_acc;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic walk_last;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

### hdl/kt_ctrl.sv
// ----------------------------------------------------------------------------
// kt_ctrl
// Sequencer: clearing pass, pair add, grid walk, divide and result transfer.
// ----------------------------------------------------------------------------
module kt_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_command,
    input  kt_pkg::t_sts i_sts,
    output logic         o_in_stall,
    output kt_pkg::t_cmd o_cmd
);
    import kt_pkg::*;

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_ADD  = 9'b000000100,
        S_WRD  = 9'b000001000,
        S_WMUL = 9'b000010000,
        S_WACC = 9'b000100000,
        S_DIV0 = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_command == CMD_FIN) begin
                        o_cmd.fin_acc = 1'b1;
                        n_state       = S_WRD;
                    end else begin
                        o_cmd.add_acc = 1'b1;
                        n_state       = S_ADD;
                    end
                end
            end
            S_ADD: begin
                o_cmd.add_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_WRD: begin
                o_cmd.walk_rd = 1'b1;
                n_state       = S_WMUL;
            end
            S_WMUL: begin
                o_cmd.walk_mul = 1'b1;
                n_state        = S_WACC;
            end
            S_WACC: begin
                o_cmd.walk_acc = 1'b1;
                n_state        = i_sts.walk_last ? S_DIV0 : S_WRD;
            end
            S_DIV0: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

endmodule

### hdl/kt_dp.sv
// ----------------------------------------------------------------------------
// kt_dp
// Datapath: count grid, column counts, score accumulator, divider, result.
// ----------------------------------------------------------------------------
module kt_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kt_pkg::t_in_item  i_in_data,
    input  kt_pkg::t_cmd      i_cmd,
    input  logic              i_out_stall,
    output kt_pkg::t_sts      o_sts,
    output logic              o_out_valid,
    output kt_pkg::t_out_item o_out_data
);
    import kt_pkg::*;

    logic [CNT_W-1:0]  r_grid [DEPTH];
    logic [CNT_W-1:0]  r_grid_q;
    logic [CNT_W-1:0]  r_colmem [COLS];
    logic [CNT_W-1:0]  r_col_q;

    logic [ADDR_W-1:0] rd_addr, wr_addr, walk_addr, in_addr;
    logic              wr_en;
    logic [CNT_W-1:0]  wr_data;

    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_add_addr;
    logic              r_add_ok;
    logic [CNT_W-1:0]  r_k;
    logic [ROW_W-1:0]  r_lf, r_row;
    logic [COL_W-1:0]  r_ls, r_col;
    logic [1:0]        r_flags, r_code;
    logic [CNT_W-1:0]  r_tot, r_less, r_rowsum;
    logic signed [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]  r_acc;
    logic [P_W-1:0]    r_p;
    logic              r_neg, r_first;
    logic [DIV_W:0]    r_rem;
    logic [Q_W-1:0]    r_q;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_out_valid;
    t_out_item         r_out;

    logic                    rank_bad;
    logic [ROW_W-1:0]        in_row;
    logic [COL_W-1:0]        in_col;
    logic [CNT_W-1:0]        ccv;
    logic signed [PRE_W-1:0] pre;
    logic [P_W-2:0]          pair;
    logic [SUM_W-1:0]        mag;
    logic [DIV_W:0]          sh, dv;
    logic                    qbit;
    logic [Q_W:0]            tau_q;

    assign in_row    = ROW_W'(i_in_data.first_rank);
    assign in_col    = COL_W'(i_in_data.second_rank);
    assign rank_bad  = (int'(i_in_data.first_rank) >= ROWS) ||
                       (int'(i_in_data.second_rank) >= COLS);
    assign in_addr   = ADDR_W'(int'(in_row) * COLS + int'(in_col));
    assign walk_addr = ADDR_W'(int'(r_row) * COLS + int'(r_col));
    assign rd_addr   = i_cmd.walk_rd ? walk_addr : in_addr;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = walk_addr;
        wr_data = '0;
        if (i_cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
        end else if (i_cmd.add_wr) begin
            wr_en   = r_add_ok;
            wr_addr = r_add_addr;
            wr_data = r_grid_q + 1'b1;
        end else if (i_cmd.walk_mul) begin
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_grid[wr_addr] <= wr_data;
        r_grid_q <= r_grid[rd_addr];
    end

    // first walked row sees zero column counts
    assign ccv = (r_row == '0) ? '0 : r_col_q;
    assign pre = $signed({1'b0, r_less, 1'b0}) + $signed({2'b0, ccv})
               - $signed({2'b0, r_tot});

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_mul) r_colmem[r_col] <= ccv + r_grid_q;
        r_col_q <= r_colmem[r_col];
    end

    assign pair  = r_p[P_W-1:1];
    assign mag   = r_acc[SUM_W-1] ? (~r_acc + 1'b1) : r_acc;
    assign sh    = r_first ? r_rem : {r_rem[DIV_W-1:0], 1'b0};
    assign dv    = {1'b0, DIV_W'(pair)};
    assign qbit  = (sh >= dv);
    assign tau_q = {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_add_ok    <= 1'b0;
            r_k         <= '0;
            r_lf        <= '0;
            r_ls        <= '0;
            r_flags     <= ERR_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) r_clr_addr <= r_clr_addr + 1'b1;

            if (i_cmd.add_acc) begin
                r_add_addr <= in_addr;
                r_add_ok   <= 1'b0;
                if (rank_bad) begin
                    r_flags <= ERR_RANK;
                end else if (r_k == COUNT_MAX) begin
                    if (r_flags != ERR_RANK) r_flags <= ERR_OVF;
                end else begin
                    r_add_ok <= 1'b1;
                    r_k      <= r_k + 1'b1;
                    if (in_row > r_lf) r_lf <= in_row;
                    if (in_col > r_ls) r_ls <= in_col;
                end
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_k         <= '0;
                r_lf        <= '0;
                r_ls        <= '0;
                r_flags     <= ERR_OK;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_acc) begin
            r_p      <= (r_k == '0) ? '0 : P_W'(r_k) * P_W'(r_k - 1'b1);
            r_row    <= '0;
            r_col    <= '0;
            r_tot    <= '0;
            r_less   <= '0;
            r_rowsum <= '0;
            r_acc    <= '0;
        end
        if (i_cmd.walk_mul) begin
            r_prod   <= pre * $signed({1'b0, r_grid_q});
            r_less   <= r_less + ccv;
            r_rowsum <= r_rowsum + r_grid_q;
        end
        if (i_cmd.walk_acc) begin
            r_acc <= r_acc + SUM_W'(r_prod);
            if (r_col == r_ls) begin
                r_col    <= '0;
                r_row    <= r_row + 1'b1;
                r_tot    <= r_tot + r_rowsum;
                r_rowsum <= '0;
                r_less   <= '0;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
        if (i_cmd.div_init) begin
            if (r_flags != ERR_OK) r_code <= r_flags;
            else if (64'(pair) > PAIR_LIMIT) r_code <= ERR_OVF;
            else if (r_k < CNT_W'(2)) r_code <= ERR_FEW;
            else r_code <= ERR_OK;
            r_neg   <= r_acc[SUM_W-1];
            r_rem   <= (DIV_W+1)'(mag);
            r_q     <= '0;
            r_dcnt  <= '0;
            r_first <= 1'b1;
        end
        if (i_cmd.div_step) begin
            r_rem   <= qbit ? (sh - dv) : sh;
            r_q     <= {r_q[Q_W-2:0], qbit};
            r_dcnt  <= r_dcnt + 1'b1;
            r_first <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out.error_code <= r_code;
            if (r_code == ERR_OK) begin
                r_out.tau_fixed       <= r_neg ? (~tau_q + 1'b1) : tau_q;
                r_out.concordance_sum <= r_acc;
                r_out.pair_total      <= 31'(pair);
            end else begin
                r_out.tau_fixed       <= '0;
                r_out.concordance_sum <= '0;
                r_out.pair_total      <= '0;
            end
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_sts.walk_last = (r_col == r_ls) && (r_row == r_lf);
    assign o_sts.div_last  = (r_dcnt == DCNT_W'(DIV_STEPS - 1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hdl/kendall_tau_rank_grid_unit.sv
// ----------------------------------------------------------------------------
// kendall_tau_rank_grid_unit
// Kendall tau-a over a 64 x 64 grid of rank pair counts.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data): command 0 adds one rank
// pair, command 1 finishes the data set. Output channel (o_out_valid /
// i_out_stall / o_out_data) carries one result per finish and none per add.
// An add reads then writes one cell in the grid memory. A finish walks
// each cell with first rank up to R and second rank up to C, R and C
// being the largest first and second ranks stored: each cell is read,
// multiplied and accumulated; a set-up step and a 15-step restoring
// divider form tau, and a last step loads the result register. The walk
// zeroes each cell it reads, so the grid is empty again after every finish.
// After reset a clearing pass zeroes all 4096 cells of the grid memory; the
// input is stalled throughout. The result sits in an output register: adds
// are still taken while it waits, but a following finish holds in its last
// cycle until the waiting result has been transferred.
// ----------------------------------------------------------------------------
module kendall_tau_rank_grid_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  kt_pkg::t_in_item  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output kt_pkg::t_out_item o_out_data
);
    import kt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    kt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_command (i_in_data.command),
        .i_sts        (sts),
        .o_in_stall   (o_in_stall),
        .o_cmd        (cmd)
    );

    kt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### hdl/kt_chk.sv
// ----------------------------------------------------------------------------
// kt_chk
// Port-level checks on the Kendall tau rank grid unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kt_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input kt_pkg::t_in_item  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input kt_pkg::t_out_item o_out_data
);
    import kt_pkg::*;

    `KT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "stalled result dropped")
    `KT_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data), "stalled result changed")
    `KT_ASSERT_NXT(a_fin_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_data.command == CMD_FIN, o_in_stall, "finish transfer did not start the walk")
    `KT_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_out_valid && o_out_data.error_code != ERR_OK, o_out_data.tau_fixed == 16'sd0 && o_out_data.concordance_sum == 32'sd0 && o_out_data.pair_total == 31'd0, "error result not zeroed")
    `KT_ASSERT_IMP(a_ok_pairs, i_clk, i_rst_n, o_out_valid && o_out_data.error_code == ERR_OK, o_out_data.pair_total != 31'd0, "good result with no pairs")

endmodule

bind kendall_tau_rank_grid_unit kt_chk u_kt_chk (.*);

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Kendall tau rank grid unit testbench
// Sends rank pairs and finishes on the input channel, predicts each finish
// result from its own pair list, and compares every result field by field.
// The output channel is stalled and the input valid is dropped at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import kt_pkg::*;

    localparam int LIMIT = 20000000;

    class tau_scoreboard;
        t_out_item     expected_q[$];
        bit [5:0]      rows_q[$];
        bit [5:0]      cols_q[$];
        logic [1:0]    err_flags;
        int            failures;
        int            results_seen;
        int            sets_done;

        function void clear_set();
            rows_q.delete();
            cols_q.delete();
            err_flags = ERR_OK;
        endfunction

        function void note_input(t_in_item it);
            longint     s, k, p, mag, q;
            int         d;
            t_out_item  r;
            if (it.command == CMD_ADD) begin
                if (it.first_rank >= ROWS || it.second_rank >= COLS) begin
                    err_flags = ERR_RANK;
                end else if (rows_q.size() >= int'(COUNT_MAX)) begin
                    if (err_flags != ERR_RANK) err_flags = ERR_OVF;
                end else begin
                    rows_q.push_back(it.first_rank);
                    cols_q.push_back(it.second_rank);
                end
                return;
            end
            k = rows_q.size();
            p = (k >= 2) ? k * (k - 1) / 2 : 0;
            r = '0;
            r.error_code = err_flags;
            if (r.error_code == ERR_OK && p > 64'h7FFF_FFFF) r.error_code = ERR_OVF;
            if (r.error_code == ERR_OK && k < 2) r.error_code = ERR_FEW;
            if (r.error_code == ERR_OK) begin
                s = 0;
                for (int i = 0; i < k; i++)
                    for (int j = i + 1; j < k; j++) begin
                        d = (int'(rows_q[i]) - int'(rows_q[j]))
                            * (int'(cols_q[i]) - int'(cols_q[j]));
                        if (d > 0) s++;
                        else if (d < 0) s--;
                    end
                mag = (s < 0) ? -s : s;
                q = (mag << 14) / p;
                r.tau_fixed = (s < 0) ? 16'(-q) : 16'(q);
                r.concordance_sum = 32'(s);
                r.pair_total = 31'(p);
            end
            expected_q.push_back(r);
            sets_done++;
            clear_set();
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer");
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (got.tau_fixed !== e.tau_fixed) begin
                $error("tau_fixed exp %0d got %0d", e.tau_fixed, got.tau_fixed);
                failures++;
            end
            if (got.concordance_sum !== e.concordance_sum) begin
                $error("concordance_sum exp %0d got %0d",
                       e.concordance_sum, got.concordance_sum);
                failures++;
            end
            if (got.pair_total !== e.pair_total) begin
                $error("pair_total exp %0d got %0d", e.pair_total, got.pair_total);
                failures++;
            end
            if (got.error_code !== e.error_code) begin
                $error("error_code exp %0d got %0d", e.error_code, got.error_code);
                failures++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;

    tau_scoreboard sb;
    bit            quiet;
    int            cycles;
    int            items_sent;

    kendall_tau_rank_grid_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            i_out_stall <= !quiet && ($urandom_range(99) < 6);
        end
    end

    task automatic send(input logic cmd, input bit [5:0] fr, input bit [5:0] sr);
        t_in_item it;
        it.command = cmd;
        it.first_rank = fr;
        it.second_rank = sr;
        while (!quiet && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int n, style, base;
        bit [5:0] a, b;
        sb = new();
        sb.clear_set();
        quiet = 1'b0;
        items_sent = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty set with ranks on the finish, single pair, extremes
        send(CMD_FIN, 6'd63, 6'd63);
        send(CMD_ADD, 6'd7, 6'd9);
        send(CMD_FIN, 6'd0, 6'd0);
        send(CMD_ADD, 6'd0, 6'd0);
        send(CMD_ADD, 6'd63, 6'd63);
        send(CMD_FIN, 6'd21, 6'd42);
        send(CMD_ADD, 6'd0, 6'd63);
        send(CMD_ADD, 6'd63, 6'd0);
        send(CMD_FIN, 6'd0, 6'd0);
        send(CMD_ADD, 6'd5, 6'd5);
        send(CMD_ADD, 6'd5, 6'd9);
        send(CMD_ADD, 6'd5, 6'd2);
        send(CMD_ADD, 6'd1, 6'd5);
        send(CMD_ADD, 6'd1, 6'd5);
        send(CMD_FIN, 6'd0, 6'd0);
        send(CMD_ADD, 6'd42, 6'd21);
        send(CMD_ADD, 6'd21, 6'd42);
        send(CMD_ADD, 6'd42, 6'd42);
        send(CMD_FIN, 6'd0, 6'd0);
        drain();

        // random sets: correlated, anti-correlated, tied and noisy
        while (items_sent < 650) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(2, 20);
            style = $urandom_range(3);
            base = $urandom_range(63);
            quiet = (items_sent > 250 && items_sent < 380);
            for (int i = 0; i < n; i++) begin
                a = 6'($urandom_range(63));
                case (style)
                    0: b = 6'(a + $urandom_range(4));
                    1: b = 6'(63 - a + $urandom_range(4));
                    2: begin
                        a = 6'(base + $urandom_range(1));
                        b = 6'($urandom_range(63));
                    end
                    default: b = 6'($urandom_range(63));
                endcase
                send(CMD_ADD, a, b);
            end
            if ($urandom_range(7) == 0) drain();
            send(CMD_FIN, 6'($urandom_range(63)), 6'($urandom_range(63)));
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d input transfers and %0d data sets, %0d results checked.",
                 items_sent, sb.sets_done, sb.results_seen);
        if (sb.failures == 0 && sb.expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
